### hdl/lrbe_pkg.sv
// Shared types, constants and the distance table of the LED ripple brightness engine.
package lrbe_pkg;

   localparam int ROWS_DEF   = 8;
   localparam int COLS_DEF   = 16;
   localparam int SLOTS_DEF  = 4;
   localparam int PIXELS_DEF = 64;
   localparam int HUES_DEF   = 360;

   localparam int ROW_W    = 3;
   localparam int COL_W    = 4;
   localparam int PIX_W    = 6;
   localparam int HUE_W    = 9;
   localparam int BRIGHT_W = 7;
   localparam int SPEED_W  = 8;
   localparam int TIME_W   = 32;
   localparam int DIST_W   = 14;

   localparam int QUEUE_DEPTH = 2;
   localparam int LUT_DEPTH   = 2 ** (ROW_W + COL_W);

   localparam logic [DIST_W-1:0] FAR_DIST   = DIST_W'(9900);
   localparam logic [DIST_W-1:0] RING_WIDTH = DIST_W'(200);

   typedef enum logic [1:0] {
      REQ_TRIGGER = 2'd0,
      REQ_FRAME   = 2'd1,
      REQ_PIXEL   = 2'd2,
      REQ_SELECT  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_FINISH,
      ST_FRAME_DIV,
      ST_FRAME_MOD
   } back_state_type;

   typedef struct packed {
      req_kind_type      kind;
      logic [TIME_W-1:0] time_ms;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
      logic [PIX_W-1:0]  pixel;
   } item_type;

   typedef struct packed {
      logic [BRIGHT_W-1:0] base_brightness;
      logic [HUE_W-1:0]    base_hue;
      logic [SPEED_W-1:0]  speed;
      logic                rainbow_mode;
      logic [BRIGHT_W-1:0] ambient_floor;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0]    pixel;
      logic [HUE_W-1:0]    hue;
      logic [BRIGHT_W-1:0] brightness;
   } result_type;

   typedef logic [LUT_DEPTH-1:0][DIST_W-1:0] dist_lut_type;

   // Exact floor(sqrt(10000 * (dr^2 + dc^2))) for every row and column offset.
   function automatic dist_lut_type build_dist_lut();
      dist_lut_type lut;
      int v;
      int r;
      int t;
      for (int ar = 0; ar < 2 ** ROW_W; ar++) begin
         for (int ac = 0; ac < 2 ** COL_W; ac++) begin
            v = 10000 * (ar * ar + ac * ac);
            r = 0;
            for (int b = 11; b >= 0; b--) begin
               t = r | (1 << b);
               if (t * t <= v) begin
                  r = t;
               end
            end
            lut[ar * (2 ** COL_W) + ac] = DIST_W'(r);
         end
      end
      return lut;
   endfunction

endpackage

### hdl/lrbe_front.sv
// Front end: accepts command words, classifies them and queues them for the back end.
module lrbe_front import lrbe_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_type,
   input  logic [TIME_W-1:0] req_time_ms,
   input  logic [ROW_W-1:0]  req_key_row,
   input  logic [COL_W-1:0]  req_key_col,
   input  logic [PIX_W-1:0]  req_pixel_index,
   output item_type          item,
   output logic              item_valid,
   input  logic              item_pop
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   item_type         head_ff;
   item_type         tail_ff;
   item_type         word_in;
   logic             push;

   assign busy       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = head_ff;
   assign push       = start && !busy;

   always_comb begin
      word_in.kind    = req_kind_type'(req_type);
      word_in.time_ms = req_time_ms;
      word_in.row     = req_key_row;
      word_in.col     = req_key_col;
      word_in.pixel   = req_pixel_index;
      count_in        = count_ff;
      if (push && !item_pop) begin
         count_in = count_ff + 1'b1;
      end else if (item_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push && item_pop) begin
         head_ff <= word_in;
      end else if (push) begin
         if (count_ff == '0) begin
            head_ff <= word_in;
         end else begin
            tail_ff <= word_in;
         end
      end else if (item_pop) begin
         head_ff <= tail_ff;
      end
   end

endmodule

### hdl/lrbe_back.sv
// Back end: ripple slot state, per-slot evaluation pipeline, pixel hue store and result register.
module lrbe_back import lrbe_pkg::*; #(
   parameter int MATRIX_ROWS  = ROWS_DEF,
   parameter int MATRIX_COLS  = COLS_DEF,
   parameter int RIPPLE_SLOTS = SLOTS_DEF,
   parameter int PIXEL_COUNT  = PIXELS_DEF,
   parameter int HUE_RANGE    = HUES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       item_valid,
   output logic       item_pop,
   input  cfg_type    cfg,
   output result_type result,
   output logic       result_valid
);

   localparam int SLOT_W       = (RIPPLE_SLOTS > 1) ? $clog2(RIPPLE_SLOTS) : 1;
   localparam int PIX_AW       = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam int PIPE_DEPTH   = 5;
   localparam int LAST_CNT     = RIPPLE_SLOTS + PIPE_DEPTH - 1;
   localparam int CNT_W        = $clog2(LAST_CNT + 1);
   localparam int RADIUS_LIMIT = MATRIX_COLS * 100;
   localparam int RETIRE_P     = ((RADIUS_LIMIT + 1) * 100 + 59) / 60;
   localparam int P_W          = $clog2(RETIRE_P);
   localparam int RAD_W        = $clog2(RADIUS_LIMIT + 1);
   localparam int R5_SHIFT     = 18;
   localparam int R5           = (2 ** R5_SHIFT + 4) / 5;
   localparam int R5P_W        = P_W + 2 + R5_SHIFT;
   localparam int FQ_SHIFT     = 20;
   localparam int RC           = (2 ** FQ_SHIFT + MATRIX_COLS - 1) / MATRIX_COLS;
   localparam int FP_W         = RAD_W + FQ_SHIFT + 1;
   localparam int RB_SHIFT     = 35;
   localparam logic [21:0] RB  = 22'(((64'd1 << RB_SHIFT) + 64'd9999) / 64'd10000);
   localparam int HQ_SHIFT     = 19;
   localparam int RH           = (2 ** HQ_SHIFT + HUE_RANGE - 1) / HUE_RANGE;
   localparam dist_lut_type DIST_LUT = build_dist_lut();

   back_state_type state_ff;
   back_state_type state_in;
   logic [CNT_W-1:0] cnt_ff;
   item_type cur_ff;

   logic [ROW_W-1:0]  slot_row_ff   [RIPPLE_SLOTS];
   logic [COL_W-1:0]  slot_col_ff   [RIPPLE_SLOTS];
   logic [TIME_W-1:0] slot_start_ff [RIPPLE_SLOTS];
   logic [HUE_W-1:0]  slot_hue_ff   [RIPPLE_SLOTS];
   logic [RIPPLE_SLOTS-1:0] slot_active_ff;
   logic [SLOT_W-1:0] next_slot_ff;
   logic [HUE_W-1:0]  rainbow_hue_ff;
   logic [TIME_W-1:0] frame_time_ff;

   logic [HUE_W-1:0]       hue_mem [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] hue_valid_ff;
   logic [HUE_W-1:0]       hue_default_ff;
   logic [HUE_W-1:0]       rd_hue_ff;
   logic                   rd_valid_ff;

   logic [HUE_W:0]   hue_sum_ff;
   logic [HUE_W:0]   hue_q_ff;
   logic [BRIGHT_W-1:0] peak_b_ff;
   logic [HUE_W-1:0]    top_hue_ff;
   logic                updated_ff;

   logic              s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [39:0]       s1_p_ff;
   logic [SLOT_W-1:0] s1_idx_ff;
   logic [ROW_W-1:0]  s1_ar_ff;
   logic [COL_W-1:0]  s1_ac_ff;
   logic [HUE_W-1:0]  s1_hue_ff, s2_hue_ff, s3_hue_ff, s4_hue_ff, s5_hue_ff;
   logic [RAD_W-1:0]  s2_rad_ff;
   logic [DIST_W-1:0] s2_dist_ff;
   logic [BRIGHT_W-1:0] s3_int_ff;
   logic [BRIGHT_W-1:0] s3_fade_ff, s4_fade_ff;
   logic [13:0]       s4_bi_ff;
   logic [20:0]       s5_bif_ff;

   logic              issue;
   logic [SLOT_W-1:0] idx;
   logic [TIME_W-1:0] elapsed;
   logic [39:0]       p_full;
   logic [ROW_W-1:0]  ar_in;
   logic [COL_W-1:0]  ac_in;
   logic              retire;
   logic [P_W+1:0]    p3;
   logic [R5P_W-1:0]  rad_prod;
   logic              far;
   logic [DIST_W-1:0] dist_in;
   logic [DIST_W-1:0] rad_ext;
   logic [DIST_W-1:0] ring;
   logic              hit;
   logic [FP_W-1:0]   fade_prod;
   logic [BRIGHT_W-1:0] fade_in;
   logic [BRIGHT_W-1:0] int_in;
   logic [42:0]       rb_prod;
   logic [BRIGHT_W-1:0] rb;
   logic [28:0]       hq_prod;
   logic [19:0]       hue_mod;
   logic              in_store;
   logic [PIX_AW-1:0] cur_addr;
   logic [PIX_AW-1:0] item_addr;
   logic [SLOT_W-1:0] next_slot_in;

   assign in_store  = ({3'b000, cur_ff.pixel} < 9'(PIXEL_COUNT));
   assign cur_addr  = PIX_AW'(cur_ff.pixel);
   assign item_addr = PIX_AW'(item.pixel);
   assign issue     = (state_ff == ST_EVAL) && (cnt_ff < CNT_W'(RIPPLE_SLOTS));
   assign idx       = cnt_ff[SLOT_W-1:0];
   assign elapsed   = frame_time_ff - slot_start_ff[idx];
   assign p_full    = 40'(elapsed) * 40'(cfg.speed);
   assign ar_in     = (cur_ff.row >= slot_row_ff[idx]) ? cur_ff.row - slot_row_ff[idx]
                                                       : slot_row_ff[idx] - cur_ff.row;
   assign ac_in     = (cur_ff.col >= slot_col_ff[idx]) ? cur_ff.col - slot_col_ff[idx]
                                                       : slot_col_ff[idx] - cur_ff.col;
   assign next_slot_in = (next_slot_ff == SLOT_W'(RIPPLE_SLOTS - 1)) ? '0
                                                                     : next_slot_ff + 1'b1;

   assign retire   = (s1_p_ff >= 40'(RETIRE_P));
   assign p3       = (P_W + 2)'({s1_p_ff[P_W-1:0], 1'b0}) + (P_W + 2)'(s1_p_ff[P_W-1:0]);
   assign rad_prod = R5P_W'(p3) * R5P_W'(R5);
   assign far      = (int'(s1_ar_ff) >= 2 * MATRIX_ROWS) || (int'(s1_ac_ff) >= 2 * MATRIX_COLS);
   assign dist_in  = far ? FAR_DIST : DIST_LUT[{s1_ar_ff, s1_ac_ff}];

   assign rad_ext   = DIST_W'(s2_rad_ff);
   assign ring      = (rad_ext > s2_dist_ff) ? rad_ext - s2_dist_ff : s2_dist_ff - rad_ext;
   assign hit       = (ring < RING_WIDTH);
   assign int_in    = BRIGHT_W'(100) - BRIGHT_W'(ring[7:1]);
   assign fade_prod = FP_W'(s2_rad_ff) * FP_W'(RC);
   assign fade_in   = BRIGHT_W'(100) - fade_prod[FQ_SHIFT +: BRIGHT_W];

   assign rb_prod = 43'(s5_bif_ff) * 43'(RB);
   assign rb      = rb_prod[RB_SHIFT +: BRIGHT_W];

   assign hq_prod = 29'(hue_sum_ff) * 29'(RH);
   assign hue_mod = 20'(hue_sum_ff) - 20'(hue_q_ff) * 20'(HUE_RANGE);

   always_comb begin
      state_in = state_ff;
      item_pop = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               if (item.kind == REQ_PIXEL) begin
                  state_in = ST_EVAL;
               end else if (item.kind == REQ_FRAME && cfg.rainbow_mode) begin
                  state_in = ST_FRAME_DIV;
               end
            end
         end
         ST_EVAL: begin
            if (cnt_ff == CNT_W'(LAST_CNT)) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH:    state_in = ST_IDLE;
         ST_FRAME_DIV: state_in = ST_FRAME_MOD;
         ST_FRAME_MOD: state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         slot_active_ff <= '0;
         next_slot_ff   <= '0;
         rainbow_hue_ff <= '0;
         frame_time_ff  <= '0;
         hue_valid_ff   <= '0;
         hue_default_ff <= '0;
         result_valid   <= 1'b0;
         s1_v_ff        <= 1'b0;
         s2_v_ff        <= 1'b0;
         s3_v_ff        <= 1'b0;
         s4_v_ff        <= 1'b0;
         s5_v_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         result_valid <= (state_ff == ST_FINISH);
         cnt_ff       <= (state_ff == ST_EVAL) ? cnt_ff + 1'b1 : '0;
         s1_v_ff      <= issue && slot_active_ff[idx];
         s2_v_ff      <= s1_v_ff && !retire;
         s3_v_ff      <= s2_v_ff && hit;
         s4_v_ff      <= s3_v_ff;
         s5_v_ff      <= s4_v_ff;
         if (s1_v_ff && retire) begin
            slot_active_ff[s1_idx_ff] <= 1'b0;
         end
         if (item_pop) begin
            unique case (item.kind)
               REQ_TRIGGER: begin
                  slot_active_ff[next_slot_ff] <= 1'b1;
                  next_slot_ff <= next_slot_in;
               end
               REQ_FRAME: frame_time_ff <= item.time_ms;
               REQ_SELECT: begin
                  rainbow_hue_ff <= cfg.base_hue;
                  hue_default_ff <= cfg.base_hue;
                  hue_valid_ff   <= '0;
               end
               default: begin
               end
            endcase
         end
         if (state_ff == ST_FRAME_MOD) begin
            rainbow_hue_ff <= hue_mod[HUE_W-1:0];
         end
         if (state_ff == ST_FINISH && updated_ff && in_store) begin
            hue_valid_ff[cur_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         cur_ff      <= item;
         peak_b_ff   <= cfg.ambient_floor;
         updated_ff  <= 1'b0;
         rd_hue_ff   <= hue_mem[item_addr];
         rd_valid_ff <= hue_valid_ff[item_addr];
         hue_sum_ff  <= (HUE_W + 1)'(rainbow_hue_ff) + (HUE_W + 1)'(cfg.speed);
         if (item.kind == REQ_TRIGGER) begin
            slot_row_ff[next_slot_ff]   <= item.row;
            slot_col_ff[next_slot_ff]   <= item.col;
            slot_start_ff[next_slot_ff] <= item.time_ms;
            slot_hue_ff[next_slot_ff]   <= cfg.rainbow_mode ? rainbow_hue_ff : cfg.base_hue;
         end
      end
      if (state_ff == ST_FRAME_DIV) begin
         hue_q_ff <= hq_prod[HQ_SHIFT +: HUE_W + 1];
      end
      if (state_ff == ST_EVAL && cnt_ff == '0) begin
         if (cfg.rainbow_mode && in_store) begin
            top_hue_ff <= rd_valid_ff ? rd_hue_ff : hue_default_ff;
         end else begin
            top_hue_ff <= '0;
         end
      end
      if (s5_v_ff && rb > peak_b_ff) begin
         peak_b_ff <= rb;
         if (cfg.rainbow_mode) begin
            top_hue_ff <= s5_hue_ff;
            updated_ff <= 1'b1;
         end
      end
      if (state_ff == ST_FINISH) begin
         result.pixel      <= cur_ff.pixel;
         result.hue        <= cfg.rainbow_mode ? top_hue_ff : cfg.base_hue;
         result.brightness <= peak_b_ff;
      end
      s1_p_ff    <= p_full;
      s1_idx_ff  <= idx;
      s1_ar_ff   <= ar_in;
      s1_ac_ff   <= ac_in;
      s1_hue_ff  <= slot_hue_ff[idx];
      s2_rad_ff  <= rad_prod[R5_SHIFT +: RAD_W];
      s2_dist_ff <= dist_in;
      s2_hue_ff  <= s1_hue_ff;
      s3_int_ff  <= int_in;
      s3_fade_ff <= fade_in;
      s3_hue_ff  <= s2_hue_ff;
      s4_bi_ff   <= 14'(s3_int_ff) * 14'(cfg.base_brightness);
      s4_fade_ff <= s3_fade_ff;
      s4_hue_ff  <= s3_hue_ff;
      s5_bif_ff  <= 21'(s4_bi_ff) * 21'(s4_fade_ff);
      s5_hue_ff  <= s4_hue_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && updated_ff && in_store) begin
         hue_mem[cur_addr] <= top_hue_ff;
      end
   end

endmodule

### hdl/led_ripple_brightness_engine.sv
// Top level of the LED ripple brightness engine: register port, front end and back end.
//
// Command words enter on start/busy: a word is taken at a clock edge with start high and
// busy low. A two-word queue sits between the front end and the back end, so busy only
// rises when the queue is full. Trigger and select words are handled as they leave the
// queue, as is a frame word, which in rainbow mode then passes a divide and a modulo state
// to advance the rainbow hue. A pixel word is loaded, issues each ripple slot in turn into
// the five-stage evaluation pipeline, waits for the pipeline to drain, and finishes; the
// back end takes no other word meanwhile. Its result then shows on the rsp_ ports, marked
// by rsp_strobe for exactly one cycle; the receiver cannot hold results off, and no other
// word gives a result. Registers are written and read through the APB port at byte
// address 4 * index; pready is always high. Register writes belong to idle periods.
// Reset empties the queue, retires every ripple, clears the frame time, rainbow hue and
// all stored pixel hues, and loads the register defaults.
module led_ripple_brightness_engine import lrbe_pkg::*; #(
   parameter int MATRIX_ROWS  = ROWS_DEF,
   parameter int MATRIX_COLS  = COLS_DEF,
   parameter int RIPPLE_SLOTS = SLOTS_DEF,
   parameter int PIXEL_COUNT  = PIXELS_DEF,
   parameter int HUE_RANGE    = HUES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [1:0]          req_type,
   input  logic [TIME_W-1:0]   req_time_ms,
   input  logic [ROW_W-1:0]    req_key_row,
   input  logic [COL_W-1:0]    req_key_col,
   input  logic [PIX_W-1:0]    req_pixel_index,
   output logic                rsp_strobe,
   output logic [PIX_W-1:0]    rsp_out_pixel,
   output logic [HUE_W-1:0]    rsp_out_hue,
   output logic [BRIGHT_W-1:0] rsp_out_brightness,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [4:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam logic [2:0] REG_BASE_BRIGHTNESS = 3'd0;
   localparam logic [2:0] REG_BASE_HUE        = 3'd1;
   localparam logic [2:0] REG_SPEED           = 3'd2;
   localparam logic [2:0] REG_AMBIENT         = 3'd3;
   localparam logic [2:0] REG_RAINBOW_MODE    = 3'd4;
   localparam int AMB_SHIFT = 21;
   localparam int AMB_R     = (2 ** AMB_SHIFT + 99) / 100;

   logic [BRIGHT_W-1:0] base_brightness_ff;
   logic [HUE_W-1:0]    base_hue_ff;
   logic [SPEED_W-1:0]  speed_ff;
   logic [BRIGHT_W-1:0] ambient_percent_ff;
   logic                rainbow_mode_ff;
   logic [13:0]         amb_prod_ff;
   logic [BRIGHT_W-1:0] amb_floor_ff;
   logic [28:0]         amb_scaled;
   logic [7:0]          amb_quot;
   logic                wr_en;
   item_type            item;
   logic                item_valid;
   logic                item_pop;
   cfg_type             cfg;
   result_type          result;

   assign pready     = 1'b1;
   assign wr_en      = psel && penable && pwrite && pready;
   assign amb_scaled = 29'(amb_prod_ff) * 29'(AMB_R);
   assign amb_quot   = amb_scaled[AMB_SHIFT +: 8];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_brightness_ff <= BRIGHT_W'(100);
         base_hue_ff        <= '0;
         speed_ff           <= SPEED_W'(1);
         ambient_percent_ff <= '0;
         rainbow_mode_ff    <= 1'b0;
      end else if (wr_en) begin
         unique case (paddr[4:2])
            REG_BASE_BRIGHTNESS: base_brightness_ff <= pwdata[BRIGHT_W-1:0];
            REG_BASE_HUE:        base_hue_ff        <= pwdata[HUE_W-1:0];
            REG_SPEED:           speed_ff           <= pwdata[SPEED_W-1:0];
            REG_AMBIENT:         ambient_percent_ff <= pwdata[BRIGHT_W-1:0];
            REG_RAINBOW_MODE:    rainbow_mode_ff    <= pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      amb_prod_ff  <= 14'(base_brightness_ff) * 14'(ambient_percent_ff);
      amb_floor_ff <= (amb_quot > 8'd127) ? BRIGHT_W'(127) : amb_quot[BRIGHT_W-1:0];
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_BASE_BRIGHTNESS: prdata = 32'(base_brightness_ff);
         REG_BASE_HUE:        prdata = 32'(base_hue_ff);
         REG_SPEED:           prdata = 32'(speed_ff);
         REG_AMBIENT:         prdata = 32'(ambient_percent_ff);
         REG_RAINBOW_MODE:    prdata = 32'(rainbow_mode_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      cfg.base_brightness = base_brightness_ff;
      cfg.base_hue        = base_hue_ff;
      cfg.speed           = speed_ff;
      cfg.rainbow_mode    = rainbow_mode_ff;
      cfg.ambient_floor   = amb_floor_ff;
   end

   lrbe_front u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_time_ms     (req_time_ms),
      .req_key_row     (req_key_row),
      .req_key_col     (req_key_col),
      .req_pixel_index (req_pixel_index),
      .item            (item),
      .item_valid      (item_valid),
      .item_pop        (item_pop)
   );

   lrbe_back #(
      .MATRIX_ROWS  (MATRIX_ROWS),
      .MATRIX_COLS  (MATRIX_COLS),
      .RIPPLE_SLOTS (RIPPLE_SLOTS),
      .PIXEL_COUNT  (PIXEL_COUNT),
      .HUE_RANGE    (HUE_RANGE)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .item         (item),
      .item_valid   (item_valid),
      .item_pop     (item_pop),
      .cfg          (cfg),
      .result       (result),
      .result_valid (rsp_strobe)
   );

   assign rsp_out_pixel      = result.pixel;
   assign rsp_out_hue        = result.hue;
   assign rsp_out_brightness = result.brightness;

`ifndef SYNTHESIS
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("Two results were issued in consecutive cycles.");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !busy && !rsp_strobe)
      else $error("Queue or result strobe survived reset.");

   a_pop_needs_word: assert property (@(posedge clock) disable iff (reset)
      item_pop |-> item_valid)
      else $error("Back end took a word from an empty queue.");
`endif

endmodule

### bench/led_ripple_brightness_engine_tb.sv
// Self-checking testbench of the LED ripple brightness engine: directed table, then random words.
module led_ripple_brightness_engine_tb;
   import lrbe_pkg::*;

   typedef struct packed {
      logic [5:0] pixel;
      logic [8:0] hue;
      logic [6:0] brightness;
   } pixel_out_type;

   typedef struct {
      req_kind_type kind;
      logic [31:0]  tms;
      logic [2:0]   row;
      logic [3:0]   col;
      logic [5:0]   pix;
      bit           fixed;
      logic [8:0]   hue;
      logic [6:0]   brightness;
   } dir_row_type;

   localparam int REG_BRIGHT  = 0;
   localparam int REG_HUE     = 1;
   localparam int REG_SPEED   = 2;
   localparam int REG_AMBIENT = 3;
   localparam int REG_RAINBOW = 4;
   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        start = 0;
   logic        busy;
   logic [1:0]  req_type = REQ_TRIGGER;
   logic [31:0] req_time_ms = 0;
   logic [2:0]  req_key_row = 0;
   logic [3:0]  req_key_col = 0;
   logic [5:0]  req_pixel_index = 0;
   logic        rsp_strobe;
   logic [5:0]  rsp_out_pixel;
   logic [8:0]  rsp_out_hue;
   logic [6:0]  rsp_out_brightness;
   logic        psel = 0;
   logic        penable = 0;
   logic        pwrite = 0;
   logic [4:0]  paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic        pready;

   led_ripple_brightness_engine u_top (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // Shadow copy of the registers and state.
   logic [6:0]  cfg_bright = 100;
   logic [8:0]  cfg_hue = 0;
   logic [7:0]  cfg_speed = 1;
   logic [6:0]  cfg_ambient = 0;
   logic        cfg_rainbow = 0;
   logic [2:0]  rip_row [4];
   logic [3:0]  rip_col [4];
   logic [31:0] rip_start [4];
   logic [8:0]  rip_hue [4];
   bit          rip_live [4];
   logic [1:0]  rip_next = 0;
   logic [8:0]  hue_cycle = 0;
   logic [31:0] latched_time = 0;
   logic [8:0]  stored_hue [64];

   pixel_out_type pending_pixels [$];
   bit          use_fixed = 0;
   pixel_out_type fixed_word;
   int          errors = 0;
   int          words_sent = 0;
   int          pixels_checked = 0;
   int          idle_cycles = 0;
   logic [31:0] clock_ms = 0;

   initial begin
      for (int i = 0; i < 4; i++) begin
         rip_row[i] = 0; rip_col[i] = 0; rip_start[i] = 0; rip_hue[i] = 0; rip_live[i] = 0;
      end
      for (int i = 0; i < 64; i++) stored_hue[i] = 0;
   end

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch on %s: got %0d, expected %0d at %0t", field, got, want, $realtime);
      errors++;
   endtask

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r = 0;
      while ((r + 1) * (r + 1) <= v) r++;
      return r;
   endfunction

   function automatic pixel_out_type evaluate_pixel(logic [2:0] row, logic [3:0] col,
                                                    logic [5:0] pix);
      pixel_out_type res;
      longint unsigned elapsed, radius, span, ring, dr, dc, glow, fade, level;
      longint unsigned peak;
      logic [8:0] best_hue;
      peak = cfg_bright * cfg_ambient / 100;
      if (peak > 127) peak = 127;
      best_hue = cfg_rainbow ? stored_hue[pix] : 9'd0;
      for (int i = 0; i < 4; i++) begin
         if (rip_live[i]) begin
            elapsed = 32'(latched_time - rip_start[i]);
            radius = elapsed * cfg_speed * 60 / 100;
            if (radius > 1600) begin
               rip_live[i] = 0;
            end else begin
               dr = row > rip_row[i] ? row - rip_row[i] : rip_row[i] - row;
               dc = col > rip_col[i] ? col - rip_col[i] : rip_col[i] - col;
               span = root_floor(10000 * (dr * dr + dc * dc));
               ring = radius > span ? radius - span : span - radius;
               if (ring < 200) begin
                  glow = 100 - ring * 100 / 200;
                  fade = 100 - radius * 100 / 1600;
                  level = cfg_bright * glow * fade / 10000;
                  if (level > peak) begin
                     peak = level;
                     if (cfg_rainbow) begin
                        best_hue = rip_hue[i];
                        stored_hue[pix] = rip_hue[i];
                     end
                  end
               end
            end
         end
      end
      res.pixel = pix;
      res.hue = cfg_rainbow ? best_hue : cfg_hue;
      res.brightness = 7'(peak);
      return res;
   endfunction

   always @(posedge clock) begin
      pixel_out_type want;
      bit seen_traffic;
      if (!reset) begin
         seen_traffic = 0;
         if (psel && penable && pwrite && pready) begin
            seen_traffic = 1;
            case (int'(paddr[4:2]))
               REG_BRIGHT:  cfg_bright = pwdata[6:0];
               REG_HUE:     cfg_hue = pwdata[8:0];
               REG_SPEED:   cfg_speed = pwdata[7:0];
               REG_AMBIENT: cfg_ambient = pwdata[6:0];
               REG_RAINBOW: cfg_rainbow = pwdata[0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            seen_traffic = 1;
            case (req_kind_type'(req_type))
               REQ_TRIGGER: begin
                  rip_row[rip_next] = req_key_row;
                  rip_col[rip_next] = req_key_col;
                  rip_start[rip_next] = req_time_ms;
                  rip_hue[rip_next] = cfg_rainbow ? hue_cycle : cfg_hue;
                  rip_live[rip_next] = 1;
                  rip_next = 2'(rip_next + 1);
               end
               REQ_FRAME: begin
                  latched_time = req_time_ms;
                  if (cfg_rainbow) hue_cycle = 9'((hue_cycle + cfg_speed) % 360);
               end
               REQ_SELECT: begin
                  hue_cycle = cfg_hue;
                  for (int i = 0; i < 64; i++) stored_hue[i] = cfg_hue;
               end
               default: begin
                  want = evaluate_pixel(req_key_row, req_key_col, req_pixel_index);
                  pending_pixels.push_back(use_fixed ? fixed_word : want);
               end
            endcase
         end
         if (rsp_strobe) begin
            seen_traffic = 1;
            if (pending_pixels.size() == 0) begin
               report_mismatch("unexpected word", rsp_out_pixel, -1);
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               if (rsp_out_pixel !== want.pixel)
                  report_mismatch("pixel", rsp_out_pixel, want.pixel);
               if (rsp_out_hue !== want.hue)
                  report_mismatch("hue", rsp_out_hue, want.hue);
               if (rsp_out_brightness !== want.brightness)
                  report_mismatch("brightness", rsp_out_brightness, want.brightness);
            end
         end
         idle_cycles <= seen_traffic ? 0 : idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d words outstanding", pending_pixels.size());
            $display("led_ripple_brightness_engine test failed");
            $finish;
         end
      end
   end

   task automatic send_word(req_kind_type kind, logic [31:0] tms, logic [2:0] row,
                            logic [3:0] col, logic [5:0] pix);
      start <= 1;
      req_type <= kind;
      req_time_ms <= tms;
      req_key_row <= row;
      req_key_col <= col;
      req_pixel_index <= pix;
      do @(posedge clock); while (busy);
      words_sent++;
   endtask

   task automatic random_gap();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return;
      start <= 0;
      if (pick < 95) repeat ($urandom_range(1, 3)) @(posedge clock);
      else repeat ($urandom_range(20, 60)) @(posedge clock);
   endtask

   task automatic drain();
      start <= 0;
      @(posedge clock);
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_reg(int index, logic [31:0] value);
      psel <= 1;
      penable <= 0;
      pwrite <= 1;
      paddr <= 5'(4 * index);
      pwdata <= value;
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0;
      penable <= 0;
      pwrite <= 0;
   endtask

   task automatic configure(logic [6:0] b, logic [8:0] h, logic [7:0] s, logic [6:0] a,
                            logic r);
      write_reg(REG_BRIGHT, 32'(b));
      write_reg(REG_HUE, 32'(h));
      write_reg(REG_SPEED, 32'(s));
      write_reg(REG_AMBIENT, 32'(a));
      write_reg(REG_RAINBOW, 32'(r));
      @(posedge clock);
   endtask

   task automatic random_phase(int count);
      int pick, step;
      logic [31:0] tms;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         step = $urandom_range(0, 2000 / (cfg_speed + 1) + 1);
         if (pick < 15) begin
            tms = clock_ms - $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0) tms = $urandom;
            send_word(REQ_TRIGGER, tms, 3'($urandom), 4'($urandom), 6'($urandom));
         end else if (pick < 35) begin
            clock_ms = clock_ms + step;
            if ($urandom_range(0, 29) == 0) clock_ms = $urandom;
            send_word(REQ_FRAME, clock_ms, 3'($urandom), 4'($urandom), 6'($urandom));
         end else if (pick < 40) begin
            send_word(REQ_SELECT, $urandom, 3'($urandom), 4'($urandom), 6'($urandom));
         end else begin
            send_word(REQ_PIXEL, $urandom, 3'($urandom), 4'($urandom), 6'($urandom));
         end
         if ($urandom_range(0, 149) == 0) drain();
         else if (n % 100 >= 30) random_gap();
      end
      drain();
   endtask

   dir_row_type plan [] = '{
      '{REQ_PIXEL,   32'd0,          3'd0, 4'd0,  6'd0,  1, 9'd0, 7'd0},
      '{REQ_FRAME,   32'd0,          3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_TRIGGER, 32'd0,          3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd0, 4'd0,  6'd63, 1, 9'd0, 7'd100},
      '{REQ_FRAME,   32'd1000,       3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd7, 4'd15, 6'd1,  1, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd0, 4'd6,  6'd2,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd0, 4'd5,  6'd3,  0, 9'd0, 7'd0},
      '{REQ_FRAME,   32'd3000,       3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd0, 4'd0,  6'd4,  1, 9'd0, 7'd0},
      '{REQ_TRIGGER, 32'hFFFFFFFF,   3'd7, 4'd15, 6'd63, 0, 9'd0, 7'd0},
      '{REQ_FRAME,   32'd0,          3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'hFFFFFFFF,   3'd7, 4'd15, 6'd5,  1, 9'd0, 7'd100},
      '{REQ_TRIGGER, 32'd0,          3'd3, 4'd8,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_TRIGGER, 32'd0,          3'd4, 4'd2,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_TRIGGER, 32'd0,          3'd1, 4'd1,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd3, 4'd8,  6'd6,  0, 9'd0, 7'd0},
      '{REQ_SELECT,  32'd0,          3'd0, 4'd0,  6'd0,  0, 9'd0, 7'd0},
      '{REQ_PIXEL,   32'd0,          3'd4, 4'd2,  6'd7,  0, 9'd0, 7'd0}
   };

   initial begin
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (plan[i]) begin
         use_fixed <= plan[i].fixed;
         fixed_word <= '{plan[i].pix, plan[i].hue, plan[i].brightness};
         send_word(plan[i].kind, plan[i].tms, plan[i].row, plan[i].col, plan[i].pix);
      end
      use_fixed <= 0;
      drain();
      random_phase(300);
      configure(7'd127, 9'd359, 8'd255, 7'd100, 1'b1);
      random_phase(250);
      configure(7'd0, 9'd0, 8'd0, 7'd0, 1'b0);
      random_phase(150);
      configure(7'd100, 9'd200, 8'd3, 7'd20, 1'b1);
      random_phase(350);
      configure(7'd100, 9'd0, 8'd1, 7'd0, 1'b0);
      random_phase(150);
      for (int p = 0; p < 4; p++) begin
         configure(7'($urandom_range(0, 127)), 9'($urandom_range(0, 511)),
                   8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)),
                   1'($urandom_range(0, 1)));
         random_phase(150);
      end
      $display("Sent %0d command words and checked %0d pixel words", words_sent,
               pixels_checked);
      $display("over solid and rainbow modes, extreme and random register settings.");
      if (errors == 0) begin
         $display("led_ripple_brightness_engine test passed");
      end else begin
         $display("led_ripple_brightness_engine test failed");
      end
      $finish;
   end

endmodule
